// File: hdl/linear_blend_vertex_skinning_assert.svh
// Assertion macros shared by the skinning block.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
// Asserts that a condition implies another at the same edge.
`define LBVS_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Asserts that a condition implies another in the next cycle.
`define LBVS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: hdl/lbvs_pkg.sv
// Package with shared types and constants of the skinning block.
package lbvs_pkg;
  localparam int MatrixSlotsDef = 64;
  localparam int MaxInfluencesDef = 4;
  localparam int WordsPerMatrix = 12;
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdSkin = 1'b1;

  typedef struct packed {
    logic        last;
    logic        skip;
    logic        pass;
    logic [16:0] weight;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } lbvs_job_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] acc);
    logic signed [47:0] v;
    v = acc[63:16];
    if (v > 48'sd2147483647) begin
      return 32'h7fffffff;
    end else if (v < -48'sd2147483648) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction
endpackage

// File: hdl/lbvs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module lbvs_ram #(
  parameter int Width = 32,
  parameter int Depth = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/lbvs_front.sv
// Front end: takes input beats, writes matrix words and queues skin jobs.
module lbvs_front #(
  parameter int MatrixSlots = lbvs_pkg::MatrixSlotsDef,
  parameter int MaxInfluences = lbvs_pkg::MaxInfluencesDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   cmd,
  input  logic [5:0]             load_slot,
  input  logic [3:0]             load_word,
  input  logic [31:0]            load_value,
  input  logic [31:0]            pos_x,
  input  logic [31:0]            pos_y,
  input  logic [31:0]            pos_z,
  input  logic [16:0]            weight,
  input  logic [5:0]             matrix_slot,
  input  logic                   last_influence,
  output logic                   we,
  output logic [$clog2(MatrixSlots*lbvs_pkg::WordsPerMatrix)-1:0] waddr,
  output logic [31:0]            wdata,
  output logic                   job_valid,
  input  logic                   job_ready,
  output lbvs_pkg::lbvs_job_t    job,
  output logic [$clog2(MatrixSlots+1)-1:0] job_slot
);
  import lbvs_pkg::*;
  localparam int AW = $clog2(MatrixSlots*WordsPerMatrix);
  localparam int SW = $clog2(MatrixSlots+1);
  localparam int CW = $clog2(MaxInfluences+1);

  logic          full_r, full_nxt;
  lbvs_job_t     job_r, job_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          stopped_r, stopped_nxt;
  logic          pass_r, pass_nxt;
  logic          acc_in;
  logic          skip;
  logic [SW-1:0] eff_slot;

  // Beats are taken only while the back end is idle, so a matrix write never
  // overtakes the reads of an earlier influence.
  assign in_tready = !full_r && job_ready;
  assign acc_in = in_tvalid && in_tready;
  assign we = acc_in && (cmd == CmdLoad) && (32'(load_slot) < MatrixSlots)
              && (load_word < 4'(WordsPerMatrix));
  assign waddr = AW'(32'(load_slot) * WordsPerMatrix + 32'(load_word));
  assign wdata = load_value;
  assign eff_slot = (32'(matrix_slot) < MatrixSlots) ? SW'(matrix_slot) : '0;
  assign skip = stopped_r || (weight == '0) || (32'(count_r) >= MaxInfluences);
  assign job_valid = full_r;
  assign job = job_r;
  assign job_slot = slot_r;

  always_comb begin
    full_nxt = full_r && !job_ready;
    job_nxt = job_r;
    slot_nxt = slot_r;
    count_nxt = count_r;
    stopped_nxt = stopped_r;
    pass_nxt = pass_r;
    if (acc_in && cmd == CmdSkin) begin
      full_nxt = 1'b1;
      slot_nxt = eff_slot;
      job_nxt.last = last_influence;
      job_nxt.skip = skip;
      job_nxt.pass = pass_r || (!stopped_r && weight == '0 && count_r == '0);
      job_nxt.weight = weight;
      job_nxt.pos_x = pos_x;
      job_nxt.pos_y = pos_y;
      job_nxt.pos_z = pos_z;
      if (!skip) begin
        count_nxt = count_r + 1'b1;
      end
      if (!stopped_r && weight == '0) begin
        stopped_nxt = 1'b1;
        pass_nxt = (count_r == '0);
      end
      if (last_influence) begin
        count_nxt = '0;
        stopped_nxt = 1'b0;
        pass_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      count_r <= '0;
      stopped_r <= 1'b0;
      pass_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
      count_r <= count_nxt;
      stopped_r <= stopped_nxt;
      pass_r <= pass_nxt;
    end
    job_r <= job_nxt;
    slot_r <= slot_nxt;
  end
endmodule

// File: hdl/lbvs_back.sv
// Back end: one multiplier walks the matrix rows, a second weights each row sum, and the rows accumulate.
module lbvs_back #(
  parameter int MatrixSlots = lbvs_pkg::MatrixSlotsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  lbvs_pkg::lbvs_job_t    job,
  input  logic [$clog2(MatrixSlots+1)-1:0] job_slot,
  output logic [$clog2(MatrixSlots*lbvs_pkg::WordsPerMatrix)-1:0] raddr,
  input  logic [31:0]            rdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [95:0]            out_tdata
);
  import lbvs_pkg::*;
  localparam int AW = $clog2(MatrixSlots*WordsPerMatrix);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_OUT  = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t       state_r, state_nxt;
  lbvs_job_t    cur_r, cur_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [3:0]   rd_r, rd_nxt;
  logic [3:0]   use_r, use_nxt;
  logic         use_v_r, use_v_nxt;
  logic         wv_r, wv_nxt;
  logic [1:0]   wrow_r, wrow_nxt;
  logic signed [63:0] acc_r [3];
  logic signed [63:0] acc_nxt [3];
  logic signed [47:0] t_r, t_nxt;
  logic signed [31:0] pick;
  logic signed [63:0] prod;
  logic signed [47:0] term;
  logic signed [17:0] wgt;
  logic signed [65:0] wprod;
  logic         out_v_r, out_v_nxt;
  logic [95:0]  out_d_r, out_d_nxt;
  logic [1:0]   row;
  logic [1:0]   col;

  assign raddr = base_r + AW'(rd_r);
  assign row = use_r[3:2];
  assign col = use_r[1:0];
  assign job_ready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  always_comb begin
    case (col)
      2'd0: pick = cur_r.pos_x;
      2'd1: pick = cur_r.pos_y;
      default: pick = cur_r.pos_z;
    endcase
    prod = 64'($signed(rdata)) * 64'(pick);
    if (col == 2'd3) begin
      term = 48'($signed(rdata) >>> 8);
    end else begin
      term = 48'(prod >>> 24);
    end
    // The row sum is weighted in the cycle after it is complete.
    wgt = $signed({1'b0, cur_r.weight});
    wprod = 66'(t_r) * 66'(wgt);
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r;
    base_nxt = base_r;
    rd_nxt = rd_r;
    use_nxt = use_r;
    use_v_nxt = 1'b0;
    wv_nxt = 1'b0;
    wrow_nxt = wrow_r;
    t_nxt = t_r;
    acc_nxt = acc_r;
    out_v_nxt = out_v_r && !out_tready;
    out_d_nxt = out_d_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          cur_nxt = job;
          base_nxt = AW'(32'(job_slot) * WordsPerMatrix);
          rd_nxt = '0;
          state_nxt = job.skip ? S_OUT : S_MAC;
        end
      end
      S_MAC: begin
        if (rd_r < 4'(WordsPerMatrix)) begin
          use_nxt = rd_r;
          use_v_nxt = 1'b1;
          rd_nxt = rd_r + 1'b1;
        end
        if (use_v_r) begin
          if (col == 2'd0) begin
            t_nxt = term;
          end else begin
            t_nxt = t_r + term;
          end
          if (col == 2'd3) begin
            wv_nxt = 1'b1;
            wrow_nxt = row;
          end
        end
        if (wv_r) begin
          acc_nxt[wrow_r] = acc_r[wrow_r] + $signed(wprod[63:0]);
          if (wrow_r == 2'd2) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!cur_r.last) begin
          state_nxt = S_IDLE;
        end else if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          if (cur_r.pass) begin
            out_d_nxt = {cur_r.pos_z, cur_r.pos_y, cur_r.pos_x};
          end else begin
            out_d_nxt = {sat32(acc_r[2]), sat32(acc_r[1]), sat32(acc_r[0])};
          end
          for (int i = 0; i < 3; i++) begin
            acc_nxt[i] = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      use_v_r <= 1'b0;
      wv_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      use_v_r <= use_v_nxt;
      wv_r <= wv_nxt;
      acc_r <= acc_nxt;
    end
    cur_r <= cur_nxt;
    base_r <= base_nxt;
    rd_r <= rd_nxt;
    use_r <= use_nxt;
    wrow_r <= wrow_nxt;
    t_r <= t_nxt;
    out_d_r <= out_d_nxt;
  end

  `include "linear_blend_vertex_skinning_assert.svh"
  `LBVS_ASSERT_IMPL(a_ready_idle, job_ready, state_r == S_IDLE)
  `LBVS_ASSERT_NEXT(a_out_hold, out_v_r && !out_tready, out_v_r && $stable(out_d_r))
  `LBVS_ASSERT_IMPL(a_use_in_mac, use_v_r, state_r == S_MAC)
  `LBVS_ASSERT_IMPL(a_weight_in_mac, wv_r, state_r == S_MAC)
endmodule

// File: hdl/linear_blend_vertex_skinning.sv
// Linear blend skinning, one vertex per run of influence beats, saturated Q16.16
// output. The block works on one beat at a time: the input is ready only while the
// back end is idle and nothing is queued. A load beat is written to the slot RAM as
// it is accepted. An influence beat that accumulates is handed to the back end, its
// twelve matrix words are read one a cycle from the slot RAM through the registered
// read port, the last row is weighted, the output step runs and the back end returns
// to idle before the next accept. An ignored influence skips the matrix reads. A last
// beat waits in the output step while the previous result is still held by out_tready.
module linear_blend_vertex_skinning #(
  parameter int MatrixSlots = lbvs_pkg::MatrixSlotsDef,
  parameter int MaxInfluences = lbvs_pkg::MaxInfluencesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // load_slot, load_word, load_value, pos_x, pos_y, pos_z, weight, matrix_slot
  input  logic [167:0] in_tdata,
  // cmd
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z
  output logic [95:0]  out_tdata
);
  import lbvs_pkg::*;
  localparam int AW = $clog2(MatrixSlots*WordsPerMatrix);
  localparam int SW = $clog2(MatrixSlots+1);

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          job_valid, job_ready;
  lbvs_job_t     job;
  logic [SW-1:0] job_slot;

  lbvs_front #(.MatrixSlots(MatrixSlots), .MaxInfluences(MaxInfluences)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .cmd(in_tuser), .load_slot(in_tdata[5:0]), .load_word(in_tdata[9:6]),
    .load_value(in_tdata[41:10]), .pos_x(in_tdata[73:42]), .pos_y(in_tdata[105:74]),
    .pos_z(in_tdata[137:106]), .weight(in_tdata[154:138]),
    .matrix_slot(in_tdata[160:155]),
    .last_influence(in_tlast),
    .we, .waddr, .wdata, .job_valid, .job_ready, .job, .job_slot
  );

  lbvs_ram #(.Width(32), .Depth(MatrixSlots*WordsPerMatrix)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  lbvs_back #(.MatrixSlots(MatrixSlots)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .job_slot, .raddr, .rdata,
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule

// File: dv/tb_linear_blend_vertex_skinning.sv
// Self-checking testbench for the linear blend vertex skinning block.
module tb_linear_blend_vertex_skinning;
  timeunit 1ns;
  timeprecision 1ps;
  import lbvs_pkg::*;

  localparam int Slots = MatrixSlotsDef;
  localparam int MaxInf = MaxInfluencesDef;
  localparam int MaxGap = 14;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic        cmd;
    logic [5:0]  load_slot;
    logic [3:0]  load_word;
    logic [31:0] load_value;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [16:0] weight;
    logic [5:0]  matrix_slot;
    logic        last;
  } skin_item_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;

  linear_blend_vertex_skinning uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [31:0]       bone_words [Slots*WordsPerMatrix];
  bit                slot_ready [Slots];
  logic signed [63:0] sum_x, sum_y, sum_z;
  int unsigned       inf_count;
  bit                halted, passing;
  logic [95:0]       skinned_q[$];
  int                errors;
  int                n_items, n_vertices, n_results, n_pass;
  int                gap_max, stall_max;
  int                stall_left;
  longint            cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               skinned_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic logic signed [63:0] row_dot(input int base, input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
    logic signed [63:0] a, b, c, d;
    a = 64'($signed(bone_words[base])) * 64'(x);
    b = 64'($signed(bone_words[base+1])) * 64'(y);
    c = 64'($signed(bone_words[base+2])) * 64'(z);
    d = 64'($signed(bone_words[base+3]));
    return (a >>> 24) + (b >>> 24) + (c >>> 24) + (d >>> 8);
  endfunction

  function automatic logic [31:0] clamp_q16(input logic signed [63:0] acc);
    logic signed [63:0] v;
    v = acc >>> 16;
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Updates the mirrored block state for one accepted beat.
  task automatic skin_predict(input skin_item_t it);
    int base;
    logic signed [63:0] w;
    if (it.cmd == CmdLoad) begin
      if (it.load_word < WordsPerMatrix && it.load_slot < Slots)
        bone_words[it.load_slot*WordsPerMatrix + it.load_word] = it.load_value;
      return;
    end
    w = {47'd0, it.weight};
    if (!halted) begin
      if (it.weight == 0) begin
        if (inf_count == 0) passing = 1'b1;
        halted = 1'b1;
      end else if (inf_count < MaxInf) begin
        base = ((it.matrix_slot < Slots) ? int'(it.matrix_slot) : 0) * WordsPerMatrix;
        sum_x += row_dot(base, it.pos_x, it.pos_y, it.pos_z) * w;
        sum_y += row_dot(base + 4, it.pos_x, it.pos_y, it.pos_z) * w;
        sum_z += row_dot(base + 8, it.pos_x, it.pos_y, it.pos_z) * w;
        inf_count++;
      end
    end
    if (!it.last) return;
    if (passing) begin
      skinned_q.push_back({it.pos_z, it.pos_y, it.pos_x});
      n_pass++;
    end else begin
      skinned_q.push_back({clamp_q16(sum_z), clamp_q16(sum_y), clamp_q16(sum_x)});
    end
    sum_x = 0; sum_y = 0; sum_z = 0;
    inf_count = 0; halted = 1'b0; passing = 1'b0;
  endtask

  task automatic send_beat(input skin_item_t it);
    logic [160:0] packed_beat;
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    packed_beat = {it.matrix_slot, it.weight, it.pos_z, it.pos_y, it.pos_x, it.load_value,
                   it.load_word, it.load_slot};
    in_tvalid <= 1'b1;
    in_tdata  <= 168'(packed_beat);
    in_tuser  <= it.cmd;
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    skin_predict(it);
    n_items++;
    if (it.cmd == CmdSkin && it.last) n_vertices++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (skinned_q.size() == 0) begin
          report($sformatf("unexpected vertex %h", out_tdata));
        end else begin
          logic [95:0] exp_v;
          exp_v = skinned_q.pop_front();
          if (out_tdata[31:0] !== exp_v[31:0])
            report($sformatf("x got %h want %h", out_tdata[31:0], exp_v[31:0]));
          if (out_tdata[63:32] !== exp_v[63:32])
            report($sformatf("y got %h want %h", out_tdata[63:32], exp_v[63:32]));
          if (out_tdata[95:64] !== exp_v[95:64])
            report($sformatf("z got %h want %h", out_tdata[95:64], exp_v[95:64]));
        end
        stall_left = $urandom_range(0, stall_max);
        if (stall_left != 0) out_tready <= 1'b0;
      end else if (!out_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) out_tready <= 1'b1;
      end
    end
  end

  function automatic skin_item_t load_item(input int slot, input int word,
                                           input logic [31:0] value);
    skin_item_t it;
    it = '{default: '0};
    it.cmd = CmdLoad;
    it.load_slot = 6'(slot);
    it.load_word = 4'(word);
    it.load_value = value;
    it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
    it.weight = 17'($urandom); it.matrix_slot = 6'($urandom); it.last = 1'($urandom);
    return it;
  endfunction

  function automatic skin_item_t skin_item(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z, input logic [16:0] w,
                                           input int slot, input bit last);
    skin_item_t it;
    it = '{default: '0};
    it.cmd = CmdSkin;
    it.load_slot = 6'($urandom); it.load_word = 4'($urandom); it.load_value = $urandom;
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.weight = w;
    it.matrix_slot = 6'(slot);
    it.last = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h03ffffff)) - 32'sh01ffffff;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1ffff;
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  // Picks a slot whose matrix has been loaded completely.
  function automatic int pick_slot();
    int s;
    s = $urandom_range(0, Slots - 1);
    while (!slot_ready[s]) s = $urandom_range(0, Slots - 1);
    return s;
  endfunction

  // Fills the lowest and the highest sixteen bone slots; slot 0 identity, 1 all max,
  // 2 all min, the others random.
  task automatic test_load_bones();
    logic [31:0] v;
    for (int s = 0; s < Slots; s++) begin
      if (s < 16 || s >= Slots - 16) begin
        for (int k = 0; k < WordsPerMatrix; k++) begin
          if (s == 0) v = (k % 5 == 0) ? 32'h01000000 : 32'h0;
          else if (s == 1) v = 32'h7fffffff;
          else if (s == 2) v = 32'h80000000;
          else v = rand_word();
          send_beat(load_item(s, k, v));
        end
        slot_ready[s] = 1'b1;
      end
    end
  endtask

  task automatic test_directed();
    // Identity bone with full weight returns the position.
    send_beat(skin_item(32'h00012345, 32'hfffe0000, 32'h7fffffff, 17'd65536, 0, 1));
    // Extreme bones and positions drive the output into saturation both ways.
    send_beat(skin_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 17'h1ffff, 1, 1));
    send_beat(skin_item(32'h80000000, 32'h80000000, 32'h80000000, 17'h1ffff, 1, 1));
    send_beat(skin_item(32'h7fffffff, 32'h80000000, 32'h00000000, 17'h1ffff, 2, 1));
    // A zero first weight passes the position through, later beats add nothing.
    send_beat(skin_item(32'hdeadbeef, 32'h00000001, 32'h80000000, 17'd0, 3, 0));
    send_beat(skin_item(32'hdeadbeef, 32'h00000001, 32'h80000000, 17'd65536, 3, 1));
    // A later zero weight stops accumulation without pass-through.
    send_beat(skin_item(32'h00030000, 32'h00010000, 32'hffff0000, 17'd32768, 4, 0));
    send_beat(skin_item(32'h00030000, 32'h00010000, 32'hffff0000, 17'd0, 5, 0));
    send_beat(skin_item(32'h00030000, 32'h00010000, 32'hffff0000, 17'd40000, 6, 1));
    // Six influences: the fifth and sixth are ignored.
    for (int i = 0; i < 6; i++)
      send_beat(skin_item(32'h00050000, 32'hfffb8000, 32'h00002000, 17'd16384, i + 3, i == 5));
    // Loads with a word index above eleven are dropped, high slots are written.
    send_beat(load_item(7, 12, 32'hffffffff));
    send_beat(load_item(7, 15, 32'h12345678));
    send_beat(load_item(63, 11, 32'h0));
    // High slot bits set on an influence.
    send_beat(skin_item(32'h00010000, 32'h00010000, 32'h00010000, 17'd1, 6'h37, 1));
  endtask

  task automatic test_random(input int n_target);
    int start, n_inf, slot;
    logic [31:0] x, y, z;
    start = n_items;
    while (n_items - start < n_target) begin
      if (($urandom_range(0, 49)) == 0) begin
        gap_max = $urandom_range(0, 1) ? 0 : MaxGap;
        stall_max = $urandom_range(0, 1) ? 0 : MaxGap;
      end
      if ($urandom_range(0, 9) == 0) begin
        slot = $urandom_range(0, 15);
        send_beat(load_item($urandom_range(0, 1) ? slot : $urandom_range(16, 63),
                            $urandom_range(0, 15), rand_word()));
      end else begin
        n_inf = $urandom_range(1, 6);
        x = rand_pos(); y = rand_pos(); z = rand_pos();
        for (int i = 0; i < n_inf; i++)
          send_beat(skin_item(x, y, z, rand_weight(), pick_slot(), i == n_inf - 1));
      end
    end
  endtask

  initial begin
    errors = 0; n_items = 0; n_vertices = 0; n_results = 0; n_pass = 0;
    cycles = 0; stall_left = 0;
    gap_max = MaxGap; stall_max = MaxGap;
    sum_x = 0; sum_y = 0; sum_z = 0; inf_count = 0; halted = 0; passing = 0;
    foreach (slot_ready[i]) slot_ready[i] = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; in_tlast = 1'b0;
    out_tready = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_bones();
    test_directed();
    test_random(650);
    in_tvalid <= 1'b0;
    while (skinned_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d beats, %0d vertices; checked %0d results (%0d pass-through).",
             n_items, n_vertices, n_results, n_pass);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
